[rtl/core/tcsb_pkg.sv]
`timescale 1ns / 1ps

package tcsb_pkg;

  localparam int CHAR_W = 8;
  localparam int CMD_W  = 2;

  // command codes carried on tuser
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // control bytes recognised by a put
  localparam logic [CHAR_W-1:0] CODE_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_DEL = 8'd127;

  localparam logic [CHAR_W-1:0] CHAR_EMPTY = 8'd0;

endpackage

[rtl/core/tcsb_ram.sv]
`timescale 1ns / 1ps

module tcsb_ram #(
  parameter int DEPTH  = 896,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/core/tcsb_seq.sv]
`timescale 1ns / 1ps

module tcsb_seq #(
  parameter int TEXT_ROWS = 14,
  parameter int TEXT_COLS = 50,
  parameter int ROW_W     = 4,
  parameter int COL_W     = 6,
  parameter int CUR_W     = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tcsb_pkg::CMD_W-1:0]  cmd,
  input  logic [tcsb_pkg::CHAR_W-1:0] code,
  input  logic [ROW_W-1:0]           rrow,
  input  logic [COL_W-1:0]           rcol,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [tcsb_pkg::CHAR_W-1:0] res_cell,
  output logic [ROW_W-1:0]           res_row,
  output logic [CUR_W-1:0]           res_col,
  output logic                       ram_we,
  output logic [ROW_W+COL_W-1:0]     ram_addr,
  output logic [tcsb_pkg::CHAR_W-1:0] ram_wdata,
  input  logic [tcsb_pkg::CHAR_W-1:0] ram_rdata
);

  import tcsb_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_RWAIT  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLS - 1);

  logic [2:0]           state;
  logic [ROW_W-1:0]     cur_row;
  logic [CUR_W-1:0]     cur_col;
  logic [ROW_W-1:0]     base;
  logic [TEXT_ROWS-1:0] row_valid;

  logic [ROW_W-1:0]     wphys;
  logic [COL_W-1:0]     wcol;
  logic [CHAR_W-1:0]    wdata;
  logic [COL_W-1:0]     cnt;
  logic [ROW_W-1:0]     rrow_q;
  logic [COL_W-1:0]     rcol_q;
  logic                 rd_ok;
  logic                 rd_hit;
  logic [CHAR_W-1:0]    rd_char;

  logic [ROW_W-1:0]     map_row;
  logic [ROW_W:0]       map_sum;
  logic [ROW_W-1:0]     phys;
  logic [ROW_W-1:0]     base_inc;
  logic                 on_last_row;
  logic                 row_full;
  logic                 in_range;

  // logical to physical row: rows form a ring starting at base
  always_comb begin
    map_row = (state == ST_READ) ? rrow_q : cur_row;
    map_sum = {1'b0, base} + {1'b0, map_row};
    if (map_sum >= (ROW_W + 1)'(TEXT_ROWS)) begin
      phys = ROW_W'(map_sum - (ROW_W + 1)'(TEXT_ROWS));
    end else begin
      phys = map_sum[ROW_W-1:0];
    end
    base_inc    = (base == LAST_ROW) ? '0 : base + 1'b1;
    on_last_row = (cur_row == LAST_ROW);
    row_full    = (cur_col >= CUR_W'(TEXT_COLS));
    in_range    = ((ROW_W + 1)'(rrow) < (ROW_W + 1)'(TEXT_ROWS))
                  && ((COL_W + 1)'(rcol) < (COL_W + 1)'(TEXT_COLS));
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);
  assign res_cell  = rd_char;
  assign res_row   = cur_row;
  assign res_col   = cur_col;

  always_comb begin
    ram_we    = (state == ST_SWEEP) || (state == ST_WRITE);
    ram_wdata = (state == ST_SWEEP) ? CHAR_EMPTY : wdata;
    unique case (state)
      ST_READ:  ram_addr = {phys, rcol_q};
      ST_SWEEP: ram_addr = {wphys, cnt};
      default:  ram_addr = {wphys, wcol};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_row   <= '0;
      cur_col   <= '0;
      base      <= '0;
      row_valid <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rd_char <= CHAR_EMPTY;
            unique case (cmd)
              CMD_PUT: begin
                if (code == CODE_LF || code == CODE_CR) begin
                  // line advance; on the bottom row rotate the ring and drop the old top
                  if (on_last_row) begin
                    base            <= base_inc;
                    row_valid[base] <= 1'b0;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                  cur_col <= '0;
                  state   <= ST_RESULT;
                end else if (code == CODE_BS || code == CODE_DEL) begin
                  if (cur_col != '0) begin
                    cur_col <= cur_col - 1'b1;
                    wcol    <= COL_W'(cur_col - 1'b1);
                    wdata   <= CHAR_EMPTY;
                    state   <= ST_PREP;
                  end else begin
                    state <= ST_RESULT;
                  end
                end else begin
                  if (row_full) begin
                    if (on_last_row) begin
                      base            <= base_inc;
                      row_valid[base] <= 1'b0;
                    end else begin
                      cur_row <= cur_row + 1'b1;
                    end
                    wcol    <= '0;
                    cur_col <= CUR_W'(1);
                  end else begin
                    wcol    <= cur_col[COL_W-1:0];
                    cur_col <= cur_col + 1'b1;
                  end
                  wdata <= code;
                  state <= ST_PREP;
                end
              end
              CMD_READ: begin
                rrow_q <= in_range ? rrow : '0;
                rcol_q <= in_range ? rcol : '0;
                rd_ok  <= in_range;
                state  <= ST_READ;
              end
              CMD_CLEAR: begin
                row_valid <= '0;
                base      <= '0;
                cur_row   <= '0;
                cur_col   <= '0;
                state     <= ST_RESULT;
              end
              default: begin
                state <= ST_RESULT;
              end
            endcase
          end
        end
        ST_PREP: begin
          wphys <= phys;
          cnt   <= '0;
          state <= row_valid[phys] ? ST_WRITE : ST_SWEEP;
        end
        ST_SWEEP: begin
          // blank a fresh row before its first write
          if (cnt == LAST_COL) begin
            row_valid[wphys] <= 1'b1;
            state            <= ST_WRITE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WRITE: begin
          state <= ST_RESULT;
        end
        ST_READ: begin
          rd_hit <= rd_ok && row_valid[phys];
          state  <= ST_RWAIT;
        end
        ST_RWAIT: begin
          rd_char <= rd_hit ? ram_rdata : CHAR_EMPTY;
          state   <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_sweep_fresh_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> !row_valid[wphys])
    else $error("sweep on a row already valid");

  a_write_valid_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> row_valid[wphys])
    else $error("write into a row that was not blanked");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESULT |-> (cur_row <= LAST_ROW) && (cur_col <= CUR_W'(TEXT_COLS))
                           && (base <= LAST_ROW))
    else $error("cursor or ring base out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(rd_char))
    else $error("result dropped before handover");
`endif

endmodule

[rtl/core/text_console_scroll_buffer_unit.sv]
`timescale 1ns / 1ps

// Text console character store with cursor and scroll.
//
// Input channel s_*: one word per command. s_tuser carries the command (put,
// read cell, clear and home); s_tdata carries the character and the read
// coordinates. Output channel m_*: exactly one word per input word, carrying
// the read cell (zero unless a read) and the cursor after the command.
//
// A newline, clear or unused command goes straight to its result; a read
// first passes the read and read-wait states, a character put the prepare
// and write states. The first write into a row that a clear or a scroll
// has emptied first blanks that row through the single store port. Rows
// live in a ring in the store, so a scroll only moves the ring base. The
// next word is taken only after the result enters the output register.
//
// Reset empties all rows at once (per-row valid flags) and homes the cursor;
// no clearing pass runs. When m_tready is low the output register holds its
// word, one more command may run to completion, then s_tready stays low.
module text_console_scroll_buffer_unit #(
  parameter int TEXT_ROWS = 14,
  parameter int TEXT_COLS = 50,
  localparam int ROW_W = $clog2(TEXT_ROWS),
  localparam int COL_W = $clog2(TEXT_COLS),
  localparam int CUR_W = $clog2(TEXT_COLS + 1),
  localparam int S_W   = ((tcsb_pkg::CHAR_W + ROW_W + COL_W + 7) / 8) * 8,
  localparam int M_W   = ((tcsb_pkg::CHAR_W + ROW_W + CUR_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_W-1:0]            s_tdata,  // char_code, read_row, read_col
  input  logic [tcsb_pkg::CMD_W-1:0] s_tuser,  // command
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_W-1:0]            m_tdata   // cell_char, cursor_row, cursor_col
);

  import tcsb_pkg::*;

  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = TEXT_ROWS * (1 << COL_W);

  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  logic              res_valid;
  logic              res_ready;
  logic [CHAR_W-1:0] res_cell;
  logic [ROW_W-1:0]  res_row;
  logic [CUR_W-1:0]  res_col;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  logic [CHAR_W-1:0] out_cell;
  logic [ROW_W-1:0]  out_row;
  logic [CUR_W-1:0]  out_col;

  // unpack the input word, lowest field first
  assign char_code = s_tdata[CHAR_W-1:0];
  assign read_row  = s_tdata[CHAR_W +: ROW_W];
  assign read_col  = s_tdata[CHAR_W + ROW_W +: COL_W];

  tcsb_seq #(
    .TEXT_ROWS (TEXT_ROWS),
    .TEXT_COLS (TEXT_COLS),
    .ROW_W     (ROW_W),
    .COL_W     (COL_W),
    .CUR_W     (CUR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser),
    .code      (char_code),
    .rrow      (read_row),
    .rcol      (read_col),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_cell  (res_cell),
    .res_row   (res_row),
    .res_col   (res_col),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  tcsb_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // output register: take a result whenever the slot is empty or draining
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_cell <= res_cell;
      out_row  <= res_row;
      out_col  <= res_col;
    end
  end

  assign m_tdata = M_W'({out_col, out_row, out_cell});

endmodule

[dv/tb_text_console_scroll_buffer_unit.sv]
`timescale 1ns / 1ps

module tb_text_console_scroll_buffer_unit;
  import tcsb_pkg::*;

  localparam int TEXT_ROWS    = 14;
  localparam int TEXT_COLS    = 50;
  localparam int S_W          = 24;
  localparam int M_W          = 24;
  localparam int RANDOM_WORDS = 1600;
  localparam int DRAIN_CYCLES = TEXT_COLS + 16;

  // spare command code: the block must leave everything alone
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one result word: read cell plus cursor after the command
  typedef struct packed {
    logic [7:0] cell_char;
    logic [3:0] row;
    logic [5:0] col;
  } console_view_t;

  // one directed step; the literal view is used only where flagged
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [7:0]       code;
    logic [3:0]       rrow;
    logic [5:0]       rcol;
    bit               literal;
    console_view_t    view;
  } console_step_t;

  logic           clk      = 1'b0;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata  = '0;
  logic [CMD_W-1:0] s_tuser = CMD_PUT;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;

  // shadow copy of the character store and cursor
  logic [7:0]  screen [TEXT_ROWS][TEXT_COLS];
  int unsigned cur_row;
  int unsigned cur_col;

  console_view_t awaited_views[$];
  console_view_t want_view;
  console_view_t got_view;
  console_step_t directed_steps[19];

  int  error_count = 0;
  int  words_sent  = 0;
  int  stall_left  = 0;
  bit  quiet_phase = 1'b0;

  text_console_scroll_buffer_unit #(
    .TEXT_ROWS(TEXT_ROWS),
    .TEXT_COLS(TEXT_COLS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // any printable-or-not byte that the block stores rather than acts on
  function automatic logic [7:0] random_glyph();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CODE_LF || c == CODE_CR || c == CODE_BS || c == CODE_DEL) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // move to column 0 of the next row; on the bottom row scroll up and blank it
  function automatic void line_feed();
    if (cur_row + 1 < TEXT_ROWS) begin
      cur_row++;
    end else begin
      for (int r = 0; r < TEXT_ROWS - 1; r++) begin
        for (int c = 0; c < TEXT_COLS; c++) begin
          screen[r][c] = screen[r + 1][c];
        end
      end
      for (int c = 0; c < TEXT_COLS; c++) begin
        screen[TEXT_ROWS - 1][c] = CHAR_EMPTY;
      end
      cur_row = TEXT_ROWS - 1;
    end
    cur_col = 0;
  endfunction

  function automatic void wipe_screen();
    for (int r = 0; r < TEXT_ROWS; r++) begin
      for (int c = 0; c < TEXT_COLS; c++) begin
        screen[r][c] = CHAR_EMPTY;
      end
    end
    cur_row = 0;
    cur_col = 0;
  endfunction

  // advance the shadow console by one command and return the word it owes
  function automatic console_view_t console_apply(input logic [CMD_W-1:0] cmd,
                                                  input logic [7:0] code,
                                                  input logic [3:0] rrow,
                                                  input logic [5:0] rcol);
    console_view_t v;
    v.cell_char = CHAR_EMPTY;
    case (cmd)
      CMD_PUT: begin
        if (code == CODE_LF || code == CODE_CR) begin
          line_feed();
        end else if (code == CODE_BS || code == CODE_DEL) begin
          // at column 0 a rubout does nothing; on a full row it blanks the last cell
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row][cur_col] = CHAR_EMPTY;
          end
        end else begin
          if (cur_col >= TEXT_COLS) begin
            line_feed();
          end
          screen[cur_row][cur_col] = code;
          cur_col++;
        end
      end
      CMD_READ: begin
        // off-screen reads return an empty cell
        if (rrow < TEXT_ROWS && rcol < TEXT_COLS) begin
          v.cell_char = screen[rrow][rcol];
        end
      end
      CMD_CLEAR: begin
        wipe_screen();
      end
      default: begin
      end
    endcase
    v.row = cur_row[3:0];
    v.col = cur_col[5:0];
    return v;
  endfunction

  // present one command word, hold it until taken, then log what it owes
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [7:0] code,
                              input logic [3:0] rrow, input logic [5:0] rcol,
                              input bit literal, input console_view_t lit_view);
    int gap;
    console_view_t v;
    gap = quiet_phase ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, rcol, rrow, code};
    do @(posedge clk); while (!s_tready);
    v = console_apply(cmd, code, rrow, rcol);
    awaited_views.push_back(literal ? lit_view : v);
    words_sent++;
  endtask

  task automatic send_read(input bit full_range);
    if (full_range) begin
      send_command(CMD_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                   6'($urandom_range(0, 63)), 1'b0, '0);
    end else begin
      send_command(CMD_READ, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, TEXT_ROWS - 1)),
                   6'($urandom_range(0, TEXT_COLS - 1)), 1'b0, '0);
    end
  endtask

  // stall the result side at random, except in the quiet phase
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        stall_left <= idle_len();
      end
    end
  end

  // check every word that leaves the block against the oldest owed view
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_view.cell_char = m_tdata[7:0];
      got_view.row       = m_tdata[11:8];
      got_view.col       = m_tdata[17:12];
      if (awaited_views.size() == 0) begin
        $display("%0t: word %h with nothing owed", $time, m_tdata);
        error_count++;
      end else begin
        want_view = awaited_views.pop_front();
        if (got_view.cell_char !== want_view.cell_char) begin
          $display("%0t: cell_char expected %h got %h", $time, want_view.cell_char,
                   got_view.cell_char);
          error_count++;
        end
        if (got_view.row !== want_view.row) begin
          $display("%0t: cursor_row expected %0d got %0d", $time, want_view.row,
                   got_view.row);
          error_count++;
        end
        if (got_view.col !== want_view.col) begin
          $display("%0t: cursor_col expected %0d got %0d", $time, want_view.col,
                   got_view.col);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int pick;
    int n;
    int random_start;

    // reads, puts, extremes, rubouts, newlines and a clear from a freshly reset console
    directed_steps = '{
      '{CMD_READ,   8'h00,   4'd0,  6'd0,  1'b1, '{8'h00, 4'd0, 6'd0}},
      '{CMD_READ,   8'hFF,   4'd15, 6'd63, 1'b1, '{8'h00, 4'd0, 6'd0}},
      '{CMD_UNUSED, 8'hFF,   4'd15, 6'd63, 1'b1, '{8'h00, 4'd0, 6'd0}},
      '{CMD_PUT,    8'h00,   4'd0,  6'd0,  1'b1, '{8'h00, 4'd0, 6'd1}},
      '{CMD_PUT,    8'hFF,   4'd0,  6'd0,  1'b1, '{8'h00, 4'd0, 6'd2}},
      '{CMD_READ,   8'h00,   4'd0,  6'd1,  1'b1, '{8'hFF, 4'd0, 6'd2}},
      '{CMD_PUT,    CODE_BS, 4'd0,  6'd0,  1'b1, '{8'h00, 4'd0, 6'd1}},
      '{CMD_READ,   8'h00,   4'd0,  6'd1,  1'b1, '{8'h00, 4'd0, 6'd1}},
      '{CMD_PUT,    CODE_DEL, 4'd0, 6'd0,  1'b1, '{8'h00, 4'd0, 6'd0}},
      '{CMD_PUT,    CODE_BS, 4'd0,  6'd0,  1'b1, '{8'h00, 4'd0, 6'd0}},
      '{CMD_PUT,    CODE_LF, 4'd0,  6'd0,  1'b1, '{8'h00, 4'd1, 6'd0}},
      '{CMD_PUT,    CODE_CR, 4'd0,  6'd0,  1'b1, '{8'h00, 4'd2, 6'd0}},
      '{CMD_PUT,    8'h41,   4'd0,  6'd0,  1'b1, '{8'h00, 4'd2, 6'd1}},
      '{CMD_READ,   8'h00,   4'd13, 6'd49, 1'b1, '{8'h00, 4'd2, 6'd1}},
      '{CMD_READ,   8'h00,   4'd14, 6'd0,  1'b1, '{8'h00, 4'd2, 6'd1}},
      '{CMD_READ,   8'h00,   4'd0,  6'd50, 1'b1, '{8'h00, 4'd2, 6'd1}},
      '{CMD_READ,   8'h00,   4'd2,  6'd0,  1'b1, '{8'h41, 4'd2, 6'd1}},
      '{CMD_CLEAR,  8'hFF,   4'd15, 6'd63, 1'b1, '{8'h00, 4'd0, 6'd0}},
      '{CMD_READ,   8'h00,   4'd2,  6'd0,  1'b1, '{8'h00, 4'd0, 6'd0}}
    };

    wipe_screen();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      send_command(directed_steps[i].cmd, directed_steps[i].code, directed_steps[i].rrow,
                   directed_steps[i].rcol, directed_steps[i].literal,
                   directed_steps[i].view);
    end

    // random part: mostly typed lines with rubouts and newlines, read-back
    // bursts over the whole screen, a little noise and the odd clear
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      quiet_phase = (((words_sent - random_start) / 200) % 4) == 2;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        send_command(CMD_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                     6'($urandom_range(0, 63)), 1'b0, '0);
      end else if (pick < 10) begin
        send_command(CMD_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)), 1'b0, '0);
      end else if (pick < 30) begin
        n = $urandom_range(1, 8);
        repeat (n) send_read($urandom_range(0, 9) == 0);
      end else begin
        // a line of text: a third are exactly one row long, some overrun and wrap
        n = ($urandom_range(0, 2) == 0) ? TEXT_COLS : $urandom_range(1, TEXT_COLS + 10);
        repeat (n) begin
          send_command(CMD_PUT, random_glyph(), 4'($urandom_range(0, 15)),
                       6'($urandom_range(0, 63)), 1'b0, '0);
          if ($urandom_range(0, 5) == 0) begin
            send_command(CMD_READ, 8'h00, cur_row[3:0],
                         6'($urandom_range(0, TEXT_COLS - 1)), 1'b0, '0);
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_command(CMD_PUT, $urandom_range(0, 1) ? CODE_BS : CODE_DEL,
                         4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)), 1'b0, '0);
          end
        end
        if ($urandom_range(0, 4) != 0) begin
          send_command(CMD_PUT, $urandom_range(0, 1) ? CODE_LF : CODE_CR,
                       4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)), 1'b0, '0);
        end
      end
    end

    // drop the request and drain what is still owed
    @(negedge clk);
    s_tvalid <= 1'b0;
    quiet_phase = 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
